### hdl/esd_pkg.sv
// shared types and constants of the escape sequence decoder
package esd_pkg;

  // parse state of the front end
  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_ESC  = 2'd1,
    PH_DIG1 = 2'd2,
    PH_DIG2 = 2'd3
  } phase_t;

  // up to three decoded bytes caused by one input item
  localparam int unsigned MAX_OUT = 3;

  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    last;
  } bundle_t;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_3    = 8'h33;
  localparam logic [7:0] CHAR_7    = 8'h37;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_N    = 8'h6E;
  localparam logic [7:0] CHAR_R    = 8'h72;
  localparam logic [7:0] CHAR_F    = 8'h66;
  localparam logic [7:0] CHAR_T    = 8'h74;
  localparam logic [7:0] CHAR_B    = 8'h62;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_TAB   = 8'h09;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_NUL   = 8'h00;

endpackage

### hdl/esd_in_if.sv
// input channel: escaped source bytes
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

### hdl/esd_out_if.sv
// output channel: decoded bytes
interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source(output valid, out_byte, run_last, string_end, input ready);
  modport sink(input valid, out_byte, run_last, string_end, output ready);
endinterface

### hdl/esd_front.sv
// front end: parses escapes and packs the decoded bytes of each item
module esd_front (
  input  logic            clk,
  input  logic            rst,
  esd_in_if.sink          text,
  output logic            push,
  output esd_pkg::bundle_t push_data,
  input  logic            full
);
  import esd_pkg::*;

  phase_t     phase, phase_next;
  logic [1:0] held_first_digit, held_first_digit_next;
  logic [2:0] held_second_digit, held_second_digit_next;

  logic       accept;
  logic       plain;
  logic       octal;
  logic [1:0] n;
  logic [7:0] fb;
  logic [7:0] fb_next;
  bundle_t    bnd;

  assign text.ready = !full;
  assign accept     = text.valid && text.ready;
  assign octal      = (text.in_byte >= CHAR_0) && (text.in_byte <= CHAR_7);
  assign fb         = (held_first_digit == 2'd0) ? CTL_NUL : (CHAR_0 + {6'd0, held_first_digit});

  // decode step, bytes are appended in order
  always_comb begin
    bnd = '0;
    n = 2'd0;
    plain = 1'b0;
    phase_next = phase;
    held_first_digit_next = held_first_digit;
    held_second_digit_next = held_second_digit;
    fb_next = CTL_NUL;

    unique case (phase)
      PH_TEXT: begin
        plain = 1'b1;
      end
      PH_ESC: begin
        phase_next = PH_TEXT;
        priority if (text.in_byte == CHAR_N) begin
          bnd.bytes[n] = CTL_LF; n = n + 2'd1;
        end else if (text.in_byte == CHAR_R) begin
          bnd.bytes[n] = CTL_CR; n = n + 2'd1;
        end else if (text.in_byte == CHAR_F) begin
          bnd.bytes[n] = CTL_FF; n = n + 2'd1;
        end else if (text.in_byte == CHAR_T) begin
          bnd.bytes[n] = CTL_TAB; n = n + 2'd1;
        end else if (text.in_byte == CHAR_B) begin
          bnd.bytes[n] = CTL_BS; n = n + 2'd1;
        end else if (text.in_byte >= CHAR_0 && text.in_byte <= CHAR_3) begin
          held_first_digit_next = text.in_byte[1:0];
          phase_next = PH_DIG1;
        end else begin
          bnd.bytes[n] = text.in_byte; n = n + 2'd1;
        end
      end
      PH_DIG1: begin
        if (octal) begin
          held_second_digit_next = text.in_byte[2:0];
          phase_next = PH_DIG2;
        end else begin
          bnd.bytes[n] = fb; n = n + 2'd1;
          plain = 1'b1;
        end
      end
      PH_DIG2: begin
        if (octal) begin
          bnd.bytes[n] = {held_first_digit, held_second_digit, text.in_byte[2:0]};
          n = n + 2'd1;
          phase_next = PH_TEXT;
        end else begin
          bnd.bytes[n] = fb; n = n + 2'd1;
          bnd.bytes[n] = CHAR_0 + {5'd0, held_second_digit}; n = n + 2'd1;
          plain = 1'b1;
        end
      end
    endcase

    // byte that restarts in normal text
    if (plain) begin
      if (text.in_byte == BACKSLASH) begin
        phase_next = PH_ESC;
      end else begin
        phase_next = PH_TEXT;
        bnd.bytes[n] = text.in_byte; n = n + 2'd1;
      end
    end

    // end of string flushes what is held
    if (text.in_last) begin
      fb_next = (held_first_digit_next == 2'd0) ? CTL_NUL
              : (CHAR_0 + {6'd0, held_first_digit_next});
      unique case (phase_next)
        PH_TEXT: begin
        end
        PH_ESC: begin
          bnd.bytes[n] = CTL_NUL; n = n + 2'd1;
        end
        PH_DIG1: begin
          bnd.bytes[n] = fb_next; n = n + 2'd1;
        end
        PH_DIG2: begin
          bnd.bytes[n] = fb_next; n = n + 2'd1;
          bnd.bytes[n] = CHAR_0 + {5'd0, held_second_digit_next}; n = n + 2'd1;
        end
      endcase
      phase_next = PH_TEXT;
    end

    bnd.cnt  = n;
    bnd.last = text.in_last;
  end

  assign push      = accept && (n != 2'd0);
  assign push_data = bnd;

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TEXT;
      held_first_digit <= 2'd0;
      held_second_digit <= 3'd0;
    end else if (accept) begin
      phase <= phase_next;
      held_first_digit <= held_first_digit_next;
      held_second_digit <= held_second_digit_next;
    end
  end

  // the final item of a string always yields a result and leaves normal text
  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && text.in_last) |-> push)
    else $error("last item produced no result");
  a_last_resets_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && text.in_last) |=> (phase == PH_TEXT))
    else $error("phase not back to text after end of string");

endmodule

### hdl/esd_queue.sv
// short queue of decoded byte bundles between front and back end
module esd_queue #(
  parameter int unsigned DEPTH = esd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  esd_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output esd_pkg::bundle_t head,
  output logic             head_valid
);
  import esd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  bundle_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

endmodule

### hdl/esd_back.sv
// back end: sends the bytes of each bundle one at a time
module esd_back (
  input  logic             clk,
  input  logic             rst,
  input  esd_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             pop,
  esd_out_if.source        decoded
);
  import esd_pkg::*;

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       final_one;
  logic       adv;

  assign final_one = (idx == (cur.cnt - 2'd1));
  assign adv       = decoded.valid && decoded.ready;
  assign pop       = head_valid && (!cur_valid || (adv && final_one));

  assign decoded.valid      = cur_valid;
  assign decoded.out_byte   = cur.bytes[idx];
  assign decoded.run_last   = final_one;
  assign decoded.string_end = final_one && cur.last;

  // control of the output bundle register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx <= 2'd0;
    end else if (adv) begin
      if (final_one) begin
        cur_valid <= 1'b0;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ((cur.cnt != 2'd0) && (idx < cur.cnt)))
    else $error("byte index outside bundle");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !adv) |-> !pop)
    else $error("bundle register overwritten while busy");

endmodule

### hdl/escape_sequence_decoder_top.sv
// escape sequence decoder: front parser, bundle queue, byte serializer
// path: decoded bytes pass through a queue entry and then the output bundle register
// throughput: one item per cycle while each item yields at most one byte and
//   decoded.ready is held; an item yielding more bytes is sent one byte at a time,
//   the queue of QUEUE_DEPTH bundles absorbs the difference, input stalls while it is full
// reset: synchronous rst returns the parser to normal text and empties the queue
module escape_sequence_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  esd_in_if.sink    text,
  esd_out_if.source decoded
);
  import esd_pkg::*;

  logic    push, full, pop, head_valid;
  bundle_t push_data, head;

  esd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  esd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .decoded    (decoded)
  );

endmodule
